>>> hw/rtl/wpe_pkg.sv
// Shared constants, register codes and control structs for the window pooling engine.
package wpe_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 7;
    localparam int WIN_CFG_BITS  = 4;
    localparam int STRIDE_BITS   = 4;
    localparam int MAP_CFG_BITS  = 7;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STRIDE        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_MODE     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_HEIGHT    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_WIDTH     = 3'd5;

    localparam logic [WIN_CFG_BITS-1:0] WINDOW_RESET = 4'd2;
    localparam logic [STRIDE_BITS-1:0]  STRIDE_RESET = 4'd2;
    localparam logic [MAP_CFG_BITS-1:0] MAP_RESET    = 7'd64;

    localparam logic POOL_MAX   = 1'b0;
    localparam logic POOL_MEAN  = 1'b1;
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic start;
        logic err;
        logic mean;
        logic take;
    } t_scan_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_scan_sts;

endpackage

>>> hw/rtl/wpe_store.sv
// Feature map memory: one write port, one read port, registered read data.
module wpe_store #(
    parameter int MAX_MAP_SIDE = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_wr_en,
    input  logic [$clog2(MAX_MAP_SIDE*MAX_MAP_SIDE)-1:0]    i_wr_addr,
    input  logic [SAMPLE_BITS-1:0]                          i_wr_data,
    input  logic                                            i_rd_en,
    input  logic [$clog2(MAX_MAP_SIDE*MAX_MAP_SIDE)-1:0]    i_rd_addr,
    output logic [SAMPLE_BITS-1:0]                          o_rd_data
);

    localparam int DEPTH = MAX_MAP_SIDE * MAX_MAP_SIDE;

    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/wpe_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module wpe_div #(
    parameter int SUM_BITS = 23,
    parameter int CNT_BITS = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SUM_BITS-1:0] i_dividend,
    input  logic [CNT_BITS-1:0]        i_divisor,
    output logic                       o_done,
    output logic signed [SUM_BITS-1:0] o_quotient
);

    localparam int STEP_BITS = $clog2(SUM_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_step;
    logic [CNT_BITS:0]    r_rem;
    logic [SUM_BITS-1:0]  r_quo;
    logic [CNT_BITS-1:0]  r_div;
    logic                 r_neg;

    logic [CNT_BITS:0]    n_shift;
    logic                 n_ge;

    always_comb begin
        n_shift = {r_rem[CNT_BITS-1:0], r_quo[SUM_BITS-1]};
        n_ge    = (n_shift >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_BITS'(1);
                if (r_step == STEP_BITS'(SUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Work on the magnitude; restore the sign at the output.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_BITS-1];
            r_quo <= i_dividend[SUM_BITS-1] ? (-i_dividend) : i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_shift - {1'b0, r_div}) : n_shift;
            r_quo <= {r_quo[SUM_BITS-2:0], n_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (-signed'(r_quo)) : signed'(r_quo);

endmodule

>>> hw/rtl/wpe_scan.sv
// Window scan sequencer: walks the window through the store and reduces it.
module wpe_scan
    import wpe_pkg::*;
#(
    parameter int MAX_MAP_SIDE = 64,
    parameter int MAX_WINDOW   = 8,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  t_scan_ctl                                     i_ctl,
    input  logic [$clog2(MAX_MAP_SIDE)-1:0]               i_r0,
    input  logic [$clog2(MAX_MAP_SIDE)-1:0]               i_c0,
    input  logic [$clog2(MAX_MAP_SIDE+1)-1:0]             i_r_end,
    input  logic [$clog2(MAX_MAP_SIDE+1)-1:0]             i_c_end,
    output t_scan_sts                                     o_sts,
    output logic                                          o_rd_en,
    output logic [$clog2(MAX_MAP_SIDE*MAX_MAP_SIDE)-1:0]  o_rd_addr,
    input  logic [SAMPLE_BITS-1:0]                        i_rd_data,
    output logic [SAMPLE_BITS-1:0]                        o_pool_value,
    output logic [$clog2(MAX_MAP_SIDE)-1:0]               o_max_row,
    output logic [$clog2(MAX_MAP_SIDE)-1:0]               o_max_col,
    output logic [$clog2(MAX_WINDOW*MAX_WINDOW+1)-1:0]    o_cells_counted,
    output logic                                          o_query_error
);

    localparam int COORD_BITS = $clog2(MAX_MAP_SIDE);
    localparam int SIDE_BITS  = $clog2(MAX_MAP_SIDE + 1);
    localparam int ADDR_BITS  = $clog2(MAX_MAP_SIDE * MAX_MAP_SIDE);
    localparam int CNT_BITS   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int SUM_BITS   = SAMPLE_BITS + CNT_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                    r_state;
    logic                          r_err;
    logic                          r_mean;
    logic [COORD_BITS-1:0]         r_c0;
    logic [SIDE_BITS-1:0]          r_r_end;
    logic [SIDE_BITS-1:0]          r_c_end;
    logic [SIDE_BITS-1:0]          r_cur_r;
    logic [SIDE_BITS-1:0]          r_cur_c;
    logic                          r_data_vld;
    logic [COORD_BITS-1:0]         r_data_r;
    logic [COORD_BITS-1:0]         r_data_c;
    logic signed [SAMPLE_BITS-1:0] r_highest;
    logic [COORD_BITS-1:0]         r_best_r;
    logic [COORD_BITS-1:0]         r_best_c;
    logic signed [SUM_BITS-1:0]    r_sum;
    logic [CNT_BITS-1:0]           r_count;
    logic                          r_div_go;
    logic [SAMPLE_BITS-1:0]        r_value;

    logic                          n_last_col;
    logic                          n_last_row;
    logic signed [SAMPLE_BITS-1:0] n_sample;
    logic                          div_done;
    logic signed [SUM_BITS-1:0]    div_quotient;

    always_comb begin
        n_last_col = ((r_cur_c + SIDE_BITS'(1)) == r_c_end);
        n_last_row = ((r_cur_r + SIDE_BITS'(1)) == r_r_end);
        n_sample   = signed'(i_rd_data);
    end

    assign o_rd_en   = (r_state == S_FETCH);
    assign o_rd_addr = ADDR_BITS'(r_cur_r[COORD_BITS-1:0]) * ADDR_BITS'(MAX_MAP_SIDE)
                     + ADDR_BITS'(r_cur_c[COORD_BITS-1:0]);

    wpe_div #(
        .SUM_BITS (SUM_BITS),
        .CNT_BITS (CNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_data_vld <= 1'b0;
            r_div_go   <= 1'b0;
        end else begin
            r_data_vld <= (r_state == S_FETCH);
            r_div_go   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= i_ctl.err ? S_DONE : S_FETCH;
                    end
                end
                S_FETCH: begin
                    if (n_last_col && n_last_row) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_mean) begin
                        r_state  <= S_DIV;
                        r_div_go <= 1'b1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_ctl.take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Window walk and reduction.
    always_ff @(posedge i_clk) begin
        r_data_r <= r_cur_r[COORD_BITS-1:0];
        r_data_c <= r_cur_c[COORD_BITS-1:0];
        if (r_state == S_IDLE && i_ctl.start) begin
            r_err     <= i_ctl.err;
            r_mean    <= i_ctl.mean;
            r_c0      <= i_c0;
            r_r_end   <= i_r_end;
            r_c_end   <= i_c_end;
            r_cur_r   <= SIDE_BITS'(i_r0);
            r_cur_c   <= SIDE_BITS'(i_c0);
            r_highest <= '0;
            r_best_r  <= i_r0;
            r_best_c  <= i_c0;
            r_sum     <= '0;
            r_count   <= '0;
        end else begin
            if (r_state == S_FETCH) begin
                if (n_last_col) begin
                    r_cur_c <= SIDE_BITS'(r_c0);
                    r_cur_r <= r_cur_r + SIDE_BITS'(1);
                end else begin
                    r_cur_c <= r_cur_c + SIDE_BITS'(1);
                end
            end
            if (r_data_vld) begin
                // Keep the first strictly highest cell in row-major order; the running highest starts at zero.
                if (n_sample > r_highest) begin
                    r_highest <= n_sample;
                    r_best_r  <= r_data_r;
                    r_best_c  <= r_data_c;
                end
                r_sum   <= r_sum + SUM_BITS'(n_sample);
                r_count <= r_count + CNT_BITS'(1);
            end
        end
        if (r_state == S_DIV && div_done) begin
            r_value <= div_quotient[SAMPLE_BITS-1:0];
        end
    end

    assign o_sts.busy      = (r_state != S_IDLE);
    assign o_sts.done      = (r_state == S_DONE);
    assign o_query_error   = r_err;
    assign o_pool_value    = r_err ? '0 : (r_mean ? r_value : r_highest);
    assign o_max_row       = r_err ? '0 : r_best_r;
    assign o_max_col       = r_err ? '0 : r_best_c;
    assign o_cells_counted = r_err ? '0 : r_count;

endmodule

>>> hw/rtl/window_pooling_engine.sv
// Top level of the window pooling engine: configuration, handshakes, store and scan.
// Load item: written to the store at the accepting edge, no result.
// Query item: window cells are read one per cycle from the single store read port; the
//   result then goes to the output register, in mean mode after the serial divider
//   (a window holds at most 64 cells). Input is stalled while a query runs.
// Reset (synchronous, active low) restores register defaults; the store is not cleared.
module window_pooling_engine
    import wpe_pkg::*;
#(
    parameter int MAX_MAP_SIDE = 64,
    parameter int MAX_WINDOW   = 8,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // input item channel
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  logic                                        i_func,
    input  logic [$clog2(MAX_MAP_SIDE)-1:0]             i_row,
    input  logic [$clog2(MAX_MAP_SIDE)-1:0]             i_col,
    input  logic signed [SAMPLE_BITS-1:0]               i_sample,
    // result item channel
    output logic                                        o_valid,
    input  logic                                        i_stall,
    output logic signed [SAMPLE_BITS-1:0]               o_pool_value,
    output logic [$clog2(MAX_MAP_SIDE)-1:0]             o_max_row,
    output logic [$clog2(MAX_MAP_SIDE)-1:0]             o_max_col,
    output logic [$clog2(MAX_WINDOW*MAX_WINDOW+1)-1:0]  o_cells_counted,
    output logic                                        o_query_error,
    // configuration write channel
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]                     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]                    i_cfg_data
);

    localparam int COORD_BITS = $clog2(MAX_MAP_SIDE);
    localparam int SIDE_BITS  = $clog2(MAX_MAP_SIDE + 1);
    localparam int WIN_BITS   = $clog2(MAX_WINDOW + 1);
    localparam int CNT_BITS   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int ADDR_BITS  = $clog2(MAX_MAP_SIDE * MAX_MAP_SIDE);
    localparam int ORG_BITS   = COORD_BITS + STRIDE_BITS;
    localparam int END_BITS   = ORG_BITS + 1;

    // ------------------------------------------------------------------
    // Configuration registers. Writes land at any edge; the scan latches
    // the geometry and mode it needs when a query starts.
    // ------------------------------------------------------------------
    logic [WIN_CFG_BITS-1:0] r_cfg_win_h;
    logic [WIN_CFG_BITS-1:0] r_cfg_win_w;
    logic [STRIDE_BITS-1:0]  r_cfg_stride;
    logic                    r_cfg_mode;
    logic [MAP_CFG_BITS-1:0] r_cfg_map_h;
    logic [MAP_CFG_BITS-1:0] r_cfg_map_w;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_win_h  <= WINDOW_RESET;
            r_cfg_win_w  <= WINDOW_RESET;
            r_cfg_stride <= STRIDE_RESET;
            r_cfg_mode   <= POOL_MAX;
            r_cfg_map_h  <= MAP_RESET;
            r_cfg_map_w  <= MAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WINDOW_HEIGHT: r_cfg_win_h  <= i_cfg_data[WIN_CFG_BITS-1:0];
                CFG_WINDOW_WIDTH:  r_cfg_win_w  <= i_cfg_data[WIN_CFG_BITS-1:0];
                CFG_STRIDE:        r_cfg_stride <= i_cfg_data[STRIDE_BITS-1:0];
                CFG_POOL_MODE:     r_cfg_mode   <= i_cfg_data[0];
                CFG_MAP_HEIGHT:    r_cfg_map_h  <= i_cfg_data[MAP_CFG_BITS-1:0];
                CFG_MAP_WIDTH:     r_cfg_map_w  <= i_cfg_data[MAP_CFG_BITS-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clamp settings: zero acts as one, oversize window and map sizes saturate.
    // ------------------------------------------------------------------
    logic [WIN_BITS-1:0]    win_h;
    logic [WIN_BITS-1:0]    win_w;
    logic [STRIDE_BITS-1:0] step;
    logic [SIDE_BITS-1:0]   map_h;
    logic [SIDE_BITS-1:0]   map_w;

    always_comb begin
        if (r_cfg_win_h == '0) begin
            win_h = WIN_BITS'(1);
        end else if (int'(r_cfg_win_h) > MAX_WINDOW) begin
            win_h = WIN_BITS'(MAX_WINDOW);
        end else begin
            win_h = WIN_BITS'(r_cfg_win_h);
        end

        if (r_cfg_win_w == '0) begin
            win_w = WIN_BITS'(1);
        end else if (int'(r_cfg_win_w) > MAX_WINDOW) begin
            win_w = WIN_BITS'(MAX_WINDOW);
        end else begin
            win_w = WIN_BITS'(r_cfg_win_w);
        end

        step = (r_cfg_stride == '0) ? STRIDE_BITS'(1) : r_cfg_stride;

        if (r_cfg_map_h == '0) begin
            map_h = SIDE_BITS'(1);
        end else if (int'(r_cfg_map_h) > MAX_MAP_SIDE) begin
            map_h = SIDE_BITS'(MAX_MAP_SIDE);
        end else begin
            map_h = SIDE_BITS'(r_cfg_map_h);
        end

        if (r_cfg_map_w == '0) begin
            map_w = SIDE_BITS'(1);
        end else if (int'(r_cfg_map_w) > MAX_MAP_SIDE) begin
            map_w = SIDE_BITS'(MAX_MAP_SIDE);
        end else begin
            map_w = SIDE_BITS'(r_cfg_map_w);
        end
    end

    // ------------------------------------------------------------------
    // Window geometry for a query. An output position is out of range
    // exactly when its origin lands at or beyond the map edge.
    // ------------------------------------------------------------------
    logic [ORG_BITS-1:0]  org_r;
    logic [ORG_BITS-1:0]  org_c;
    logic [END_BITS-1:0]  reach_r;
    logic [END_BITS-1:0]  reach_c;
    logic                 query_err;
    logic [SIDE_BITS-1:0] end_r;
    logic [SIDE_BITS-1:0] end_c;

    always_comb begin
        org_r     = ORG_BITS'(i_row) * ORG_BITS'(step);
        org_c     = ORG_BITS'(i_col) * ORG_BITS'(step);
        query_err = (END_BITS'(org_r) >= END_BITS'(map_h))
                 || (END_BITS'(org_c) >= END_BITS'(map_w));
        reach_r   = END_BITS'(org_r) + END_BITS'(win_h);
        reach_c   = END_BITS'(org_c) + END_BITS'(win_w);
        // clip the window to the map
        end_r     = (reach_r < END_BITS'(map_h)) ? SIDE_BITS'(reach_r) : map_h;
        end_c     = (reach_c < END_BITS'(map_w)) ? SIDE_BITS'(reach_c) : map_w;
    end

    // ------------------------------------------------------------------
    // Input handshake. Hold off new items while a query is in the scan.
    // ------------------------------------------------------------------
    t_scan_ctl scan_ctl;
    t_scan_sts scan_sts;
    logic      in_accept;
    logic      load_en;
    logic      out_take;

    logic                              rd_en;
    logic [ADDR_BITS-1:0]              rd_addr;
    logic [SAMPLE_BITS-1:0]            rd_data;
    logic [ADDR_BITS-1:0]              wr_addr;

    logic [SAMPLE_BITS-1:0]            scan_value;
    logic [COORD_BITS-1:0]             scan_max_row;
    logic [COORD_BITS-1:0]             scan_max_col;
    logic [CNT_BITS-1:0]               scan_count;
    logic                              scan_err;

    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_value;
    logic [COORD_BITS-1:0]  r_out_row;
    logic [COORD_BITS-1:0]  r_out_col;
    logic [CNT_BITS-1:0]    r_out_count;
    logic                   r_out_err;

    assign o_stall   = scan_sts.busy;
    assign in_accept = i_valid && !o_stall;

    // Loads beyond the store are dropped.
    assign load_en = in_accept && (i_func == FUNC_LOAD)
                  && (int'(i_row) < MAX_MAP_SIDE) && (int'(i_col) < MAX_MAP_SIDE);
    assign wr_addr = ADDR_BITS'(i_row) * ADDR_BITS'(MAX_MAP_SIDE) + ADDR_BITS'(i_col);

    // A finished result moves into the output register once it is free or draining.
    assign out_take = scan_sts.done && (!r_out_valid || !i_stall);

    always_comb begin
        scan_ctl.start = in_accept && (i_func == FUNC_QUERY);
        scan_ctl.err   = query_err;
        scan_ctl.mean  = (r_cfg_mode == POOL_MEAN);
        scan_ctl.take  = out_take;
    end

    wpe_store #(
        .MAX_MAP_SIDE (MAX_MAP_SIDE),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (load_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    wpe_scan #(
        .MAX_MAP_SIDE (MAX_MAP_SIDE),
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (scan_ctl),
        .i_r0            (org_r[COORD_BITS-1:0]),
        .i_c0            (org_c[COORD_BITS-1:0]),
        .i_r_end         (end_r),
        .i_c_end         (end_c),
        .o_sts           (scan_sts),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .o_pool_value    (scan_value),
        .o_max_row       (scan_max_row),
        .o_max_col       (scan_max_col),
        .o_cells_counted (scan_count),
        .o_query_error   (scan_err)
    );

    // ------------------------------------------------------------------
    // Output register: parts the scan from the result consumer.
    // ------------------------------------------------------------------
    always_comb begin
        if (out_take) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out_value <= scan_value;
            r_out_row   <= scan_max_row;
            r_out_col   <= scan_max_col;
            r_out_count <= scan_count;
            r_out_err   <= scan_err;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pool_value    = signed'(r_out_value);
    assign o_max_row       = r_out_row;
    assign o_max_col       = r_out_col;
    assign o_cells_counted = r_out_count;
    assign o_query_error   = r_out_err;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // An accepted query occupies the scan on the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_func == FUNC_QUERY)) |=> o_stall)
        else $error("query accepted but scan not busy");

    // A load never starts the scan.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_func == FUNC_LOAD)) |=> !o_stall)
        else $error("load left the scan busy");

    // Out-of-range results carry zero payload.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_query_error) |-> ((o_pool_value == '0) && (o_cells_counted == '0)
                                        && (o_max_row == '0) && (o_max_col == '0)))
        else $error("error result with nonzero payload");

    // A valid window always covers at least one cell.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_query_error) |-> (o_cells_counted != '0))
        else $error("in-range result with empty window");

endmodule
